// File: rtl/srs_pkg.sv
// shared types, constants and the gray conversion for the seam row selector
// no dependencies
`default_nettype none

package srs_pkg;

    localparam int PIXEL_W = 24;
    localparam int GRAY_W  = 8;
    localparam int DEPTH_W = 5;
    localparam int LIMIT_W = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // register word index taken from the byte address
    localparam logic REG_MEAN_DIFF_LIMIT = 1'b0;

    // item kinds
    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_ROW,
        S_FIN,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic acc;
        logic row_close;
        logic fin_mul;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic row_end;
        logic out_free;
    } t_status;

    // gray = (11r + 16g + 5b) / 32, truncated
    function automatic logic [GRAY_W-1:0] gray_of(input logic [PIXEL_W-1:0] px);
        logic [12:0] r;
        logic [12:0] g;
        logic [12:0] b;
        logic [12:0] s;
        r = {5'd0, px[23:16]};
        g = {5'd0, px[15:8]};
        b = {5'd0, px[7:0]};
        s = (r << 3) + (r << 1) + r + (g << 4) + (b << 2) + b;
        return s[12:5];
    endfunction

endpackage

`default_nettype wire

// File: rtl/srs_if.sv
// valid/ready channels for pixel pair items and seam depth items
// depends on srs_pkg
`default_nettype none

interface srs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [srs_pkg::PIXEL_W-1:0]  old_pixel;
    logic [srs_pkg::PIXEL_W-1:0]  new_pixel;
    logic                         row_end;

    modport source (output valid, kind, old_pixel, new_pixel, row_end, input ready);
    modport sink   (input valid, kind, old_pixel, new_pixel, row_end, output ready);
endinterface

interface srs_out_if;
    logic                         valid;
    logic                         ready;
    logic [srs_pkg::DEPTH_W-1:0]  seam_depth;

    modport source (output valid, seam_depth, input ready);
    modport sink   (input valid, seam_depth, output ready);
endinterface

`default_nettype wire

// File: rtl/srs_ctrl.sv
// controller state machine: sequences accumulate, row close and finish steps
// depends on srs_pkg
`default_nettype none

module srs_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire srs_pkg::t_status  i_status,
    output srs_pkg::t_cmd          o_cmd
);

    srs_pkg::t_state r_state;
    srs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_status.kind == srs_pkg::KIND_FINISH) ?
                              srs_pkg::S_FIN : srs_pkg::S_ACC;
                end
            end
            srs_pkg::S_ACC: begin
                n_state = i_status.row_end ? srs_pkg::S_ROW : srs_pkg::S_IDLE;
            end
            srs_pkg::S_ROW:  n_state = srs_pkg::S_IDLE;
            srs_pkg::S_FIN:  n_state = srs_pkg::S_EMIT;
            srs_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = srs_pkg::S_IDLE;
                end
            end
            default: n_state = srs_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            srs_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            srs_pkg::S_ACC:  o_cmd.acc       = 1'b1;
            srs_pkg::S_ROW:  o_cmd.row_close = 1'b1;
            srs_pkg::S_FIN:  o_cmd.fin_mul   = 1'b1;
            srs_pkg::S_EMIT: o_cmd.emit      = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/srs_dp.sv
// datapath: gray difference, row accumulation, best row tracking, output register
// depends on srs_pkg
`default_nettype none

module srs_dp #(
    parameter int MAX_DEPTH   = 24,
    parameter int MAX_SAMPLES = 2048
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire srs_pkg::t_cmd             i_cmd,
    output srs_pkg::t_status               o_status,
    input  wire                            i_kind,
    input  wire [srs_pkg::PIXEL_W-1:0]     i_old_pixel,
    input  wire [srs_pkg::PIXEL_W-1:0]     i_new_pixel,
    input  wire                            i_row_end,
    input  wire [srs_pkg::LIMIT_W-1:0]     i_mean_diff_limit,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [srs_pkg::DEPTH_W-1:0]    o_seam_depth
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = $clog2(MAX_SAMPLES * 255 + 1);
    localparam int PROD_W = CNT_W + srs_pkg::LIMIT_W;

    logic                          r_kind;
    logic                          r_row_end;
    logic [srs_pkg::GRAY_W-1:0]    r_diff;
    logic [srs_pkg::DEPTH_W-1:0]   r_row_index;
    logic [SUM_W-1:0]              r_row_sum;
    logic [CNT_W-1:0]              r_cur_count;
    logic [CNT_W-1:0]              r_sample_count;
    logic [SUM_W-1:0]              r_best_sum;
    logic [srs_pkg::DEPTH_W-1:0]   r_best_depth;
    logic                          r_best_valid;
    logic [PROD_W-1:0]             r_prod;
    logic                          r_out_valid;
    logic [srs_pkg::DEPTH_W-1:0]   r_seam_depth;

    logic [srs_pkg::GRAY_W-1:0]    gray_old;
    logic [srs_pkg::GRAY_W-1:0]    gray_new;
    logic                          rows_full;
    logic                          out_free;
    logic                          seam_ok;

    assign gray_old  = srs_pkg::gray_of(i_old_pixel);
    assign gray_new  = srs_pkg::gray_of(i_new_pixel);
    assign rows_full = r_row_index >= srs_pkg::DEPTH_W'(MAX_DEPTH);
    assign out_free  = !r_out_valid || i_out_ready;
    assign seam_ok   = r_best_valid && (r_sample_count != '0) &&
                       (PROD_W'(r_best_sum) <= r_prod);

    assign o_status.kind     = i_kind;
    assign o_status.row_end  = r_row_end;
    assign o_status.out_free = out_free;

    // item capture and absolute gray difference
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind    <= i_kind;
            r_row_end <= i_row_end;
            r_diff    <= (gray_old > gray_new) ? (gray_old - gray_new)
                                               : (gray_new - gray_old);
        end
    end

    // finish threshold product
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_mul) begin
            r_prod <= PROD_W'(i_mean_diff_limit) * PROD_W'(r_sample_count);
        end
    end

    // row accumulation and best row tracking, cleared on reset and on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_row_index    <= '0;
            r_row_sum      <= '0;
            r_cur_count    <= '0;
            r_sample_count <= '0;
            r_best_sum     <= '1;
            r_best_depth   <= '0;
            r_best_valid   <= 1'b0;
        end else if (i_cmd.acc && !rows_full && r_kind == srs_pkg::KIND_PAIR) begin
            if (r_cur_count < CNT_W'(MAX_SAMPLES)) begin
                r_row_sum   <= r_row_sum + SUM_W'(r_diff);
                r_cur_count <= r_cur_count + 1'b1;
            end
        end else if (i_cmd.row_close && !rows_full) begin
            if (r_cur_count != '0 && (!r_best_valid || r_row_sum < r_best_sum)) begin
                r_best_sum     <= r_row_sum;
                r_best_depth   <= r_row_index + 1'b1;
                r_sample_count <= r_cur_count;
                r_best_valid   <= 1'b1;
            end
            r_row_index <= r_row_index + 1'b1;
            r_row_sum   <= '0;
            r_cur_count <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_seam_depth <= seam_ok ? r_best_depth : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_seam_depth = r_seam_depth;

endmodule

`default_nettype wire

// File: rtl/seam_row_selector.sv
// seam row selector top: config register port, controller and datapath
// depends on srs_pkg, srs_if, srs_ctrl, srs_dp
// a pixel pair item is latched in idle, then accumulated, plus a row close step when it ends a row
// a finish item runs the finish product step and then emit, which waits while out is stalled
// one item at a time through the controller sequence; a new item is accepted only in idle
// reset: synchronous active-low; clears seam state and sets mean_diff_limit to 12
`default_nettype none

module seam_row_selector #(
    parameter int MAX_DEPTH   = 24,
    parameter int MAX_SAMPLES = 2048
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    srs_in_if.sink                         i_in,
    srs_out_if.source                      o_out,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [srs_pkg::ADDR_W-1:0]      paddr,
    input  wire [srs_pkg::DATA_W-1:0]      pwdata,
    output logic [srs_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic [srs_pkg::LIMIT_W-1:0] r_mean_diff_limit;
    srs_pkg::t_cmd               cmd;
    srs_pkg::t_status            status;
    logic                        in_ready;
    logic                        hit;

    assign hit    = paddr[2] == srs_pkg::REG_MEAN_DIFF_LIMIT;
    assign pready = 1'b1;

    // config register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_diff_limit <= srs_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_mean_diff_limit <= pwdata[srs_pkg::LIMIT_W-1:0];
        end
    end

    // config register read
    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(srs_pkg::DATA_W - srs_pkg::LIMIT_W){1'b0}}, r_mean_diff_limit};
        end
    end

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    srs_dp #(
        .MAX_DEPTH   (MAX_DEPTH),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_kind            (i_in.kind),
        .i_old_pixel       (i_in.old_pixel),
        .i_new_pixel       (i_in.new_pixel),
        .i_row_end         (i_in.row_end),
        .i_mean_diff_limit (r_mean_diff_limit),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_seam_depth      (o_out.seam_depth)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
